>>> rtl/hbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hbs_pkg;

  // Window geometry
  localparam int MAX_RADIUS = 15;
  localparam int MAX_BINS   = 65536;
  localparam int WIN_DEPTH  = 2 * MAX_RADIUS + 1;

  // Field widths
  localparam int DATA_W  = 32;
  localparam int RAD_W   = 4;
  localparam int TOTAL_W = 48;
  localparam int SPAN_W  = RAD_W + 1;
  localparam int CNT_W   = $clog2(WIN_DEPTH + 1);
  localparam int BINS_W  = $clog2(MAX_BINS + 1);
  localparam int SUM_W   = DATA_W + $clog2(WIN_DEPTH);

  // Registered adder tree over the window taps
  localparam int GRP    = 4;
  localparam int NUM_G1 = (WIN_DEPTH + GRP - 1) / GRP;
  localparam int NUM_G2 = (NUM_G1 + GRP - 1) / GRP;
  localparam int G1_W   = DATA_W + $clog2(GRP);
  localparam int G2_W   = G1_W + $clog2(GRP);

  // Divider: DIV_STEP quotient bits per cycle
  localparam int DIV_STEP  = 8;
  localparam int DIV_CYC   = (SUM_W + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_W     = DIV_CYC * DIV_STEP;
  localparam int DIV_CNT_W = $clog2(DIV_CYC);

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [DATA_W-1:0] bin_count;
    logic              last_bin;
  } hbs_in_t;

  typedef struct packed {
    logic [DATA_W-1:0]  smoothed_value;
    logic               result_last;
    logic [TOTAL_W-1:0] total_points;
    logic               too_short;
  } hbs_out_t;

  // One classified bin, handed from the front to the back.
  typedef struct packed {
    logic [SUM_W-1:0]  win_sum;
    logic [SPAN_W-1:0] span;
    logic [CNT_W-1:0]  count;
    logic              is_last;
    logic              too_short;
  } hbs_job_t;

endpackage

`default_nettype wire

>>> rtl/hbs_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module hbs_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire hbs_pkg::hbs_job_t push_data_i,
  input  wire logic              pop_i,
  output hbs_pkg::hbs_job_t      pop_data_o,
  output logic                   full_o,
  output logic                   empty_o
);

  hbs_pkg::hbs_job_t                  mem_q [hbs_pkg::QUEUE_DEPTH];
  logic [hbs_pkg::QPTR_W-1:0]         wr_ptr_q, wr_ptr_d;
  logic [hbs_pkg::QPTR_W-1:0]         rd_ptr_q, rd_ptr_d;
  logic [hbs_pkg::QCNT_W-1:0]         cnt_q, cnt_d;
  logic                               do_push, do_pop;

  assign full_o     = (cnt_q == hbs_pkg::QCNT_W'(hbs_pkg::QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == hbs_pkg::QPTR_W'(hbs_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wr_ptr_q + hbs_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == hbs_pkg::QPTR_W'(hbs_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rd_ptr_q + hbs_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + hbs_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - hbs_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/hbs_front.sv
`timescale 1ns / 1ps
`default_nettype none

module hbs_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [hbs_pkg::RAD_W-1:0]  radius_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire hbs_pkg::hbs_in_t           in_data_i,
  input  wire logic                       full_i,
  output logic                            push_o,
  output hbs_pkg::hbs_job_t               job_o
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_SUM1 = 2'd1;
  localparam logic [1:0] F_SUM2 = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]                    st_q, st_d;
  logic [hbs_pkg::DATA_W-1:0]    win_q [hbs_pkg::WIN_DEPTH];
  logic [hbs_pkg::BINS_W-1:0]    bins_q;
  logic [hbs_pkg::G1_W-1:0]      g1_q [hbs_pkg::NUM_G1];
  logic [hbs_pkg::G2_W-1:0]      g2_q [hbs_pkg::NUM_G2];
  logic [hbs_pkg::G1_W-1:0]      g1_d [hbs_pkg::NUM_G1];
  logic [hbs_pkg::G2_W-1:0]      g2_d [hbs_pkg::NUM_G2];
  logic [hbs_pkg::SPAN_W-1:0]    span_q;
  logic [hbs_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic                          last_q, short_q, need_q;
  logic                          short_d, need_d;
  logic [hbs_pkg::RAD_W-1:0]     rad;
  logic [hbs_pkg::SPAN_W-1:0]    span;
  logic [hbs_pkg::CNT_W-1:0]     emit0;
  logic [hbs_pkg::SUM_W-1:0]     win_sum;
  logic                          accept, push_done, clear;

  assign in_ready_o = (st_q == F_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = (st_q == F_PUSH) && need_q && !full_i;
  assign push_done  = (st_q == F_PUSH) && (!need_q || !full_i);
  assign clear      = push_done && last_q;

  // Classification of the incoming bin against the bins seen before it.
  always_comb begin
    rad  = (radius_i > hbs_pkg::RAD_W'(hbs_pkg::MAX_RADIUS))
           ? hbs_pkg::RAD_W'(hbs_pkg::MAX_RADIUS) : radius_i;
    span = {rad, 1'b1};
    if (bins_q == hbs_pkg::BINS_W'({rad, 1'b0})) begin
      emit0 = hbs_pkg::CNT_W'(rad) + hbs_pkg::CNT_W'(1);
    end else if (bins_q >= hbs_pkg::BINS_W'(span)) begin
      emit0 = hbs_pkg::CNT_W'(1);
    end else begin
      emit0 = '0;
    end
    short_d = in_data_i.last_bin && (emit0 == '0);
    need_d  = in_data_i.last_bin || (emit0 != '0);
    cnt_d   = short_d ? '0
              : emit0 + (in_data_i.last_bin ? hbs_pkg::CNT_W'(rad) : '0);
  end

  // First tree level: masked groups of window taps.
  always_comb begin
    logic [hbs_pkg::G1_W-1:0] acc;
    for (int j = 0; j < hbs_pkg::NUM_G1; j++) begin
      acc = '0;
      for (int i = 0; i < hbs_pkg::GRP; i++) begin
        if ((j * hbs_pkg::GRP + i) < hbs_pkg::WIN_DEPTH) begin
          if ((j * hbs_pkg::GRP + i) < int'(span_q)) begin
            acc = acc + hbs_pkg::G1_W'(win_q[j * hbs_pkg::GRP + i]);
          end
        end
      end
      g1_d[j] = acc;
    end
  end

  always_comb begin
    logic [hbs_pkg::G2_W-1:0] acc;
    for (int j = 0; j < hbs_pkg::NUM_G2; j++) begin
      acc = '0;
      for (int i = 0; i < hbs_pkg::GRP; i++) begin
        if ((j * hbs_pkg::GRP + i) < hbs_pkg::NUM_G1) begin
          acc = acc + hbs_pkg::G2_W'(g1_q[j * hbs_pkg::GRP + i]);
        end
      end
      g2_d[j] = acc;
    end
  end

  always_comb begin
    win_sum = '0;
    for (int j = 0; j < hbs_pkg::NUM_G2; j++) begin
      win_sum = win_sum + hbs_pkg::SUM_W'(g2_q[j]);
    end
  end

  always_comb begin
    job_o.win_sum   = win_sum;
    job_o.span      = span_q;
    job_o.count     = cnt_q;
    job_o.is_last   = last_q;
    job_o.too_short = short_q;
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      F_IDLE: begin
        if (accept) begin
          st_d = F_SUM1;
        end
      end
      F_SUM1: st_d = F_SUM2;
      F_SUM2: st_d = F_PUSH;
      F_PUSH: begin
        if (push_done) begin
          st_d = F_IDLE;
        end
      end
      default: st_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= F_IDLE;
      bins_q <= '0;
      for (int k = 0; k < hbs_pkg::WIN_DEPTH; k++) begin
        win_q[k] <= '0;
      end
    end else begin
      st_q <= st_d;
      if (accept) begin
        win_q[0] <= in_data_i.bin_count;
        for (int k = 1; k < hbs_pkg::WIN_DEPTH; k++) begin
          win_q[k] <= win_q[k-1];
        end
        if (bins_q < hbs_pkg::BINS_W'(hbs_pkg::MAX_BINS)) begin
          bins_q <= bins_q + hbs_pkg::BINS_W'(1);
        end
      end else if (clear) begin
        bins_q <= '0;
        for (int k = 0; k < hbs_pkg::WIN_DEPTH; k++) begin
          win_q[k] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      span_q  <= span;
      cnt_q   <= cnt_d;
      last_q  <= in_data_i.last_bin;
      short_q <= short_d;
      need_q  <= need_d;
    end
    if (st_q == F_SUM1) begin
      g1_q <= g1_d;
    end
    if (st_q == F_SUM2) begin
      g2_q <= g2_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/hbs_div.sv
`timescale 1ns / 1ps
`default_nettype none

module hbs_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [hbs_pkg::SUM_W-1:0]   dividend_i,
  input  wire logic [hbs_pkg::SPAN_W-1:0]  divisor_i,
  output logic                             done_o,
  output logic [hbs_pkg::DATA_W-1:0]       quotient_o
);

  logic                              busy_q, done_q;
  logic [hbs_pkg::DIV_CNT_W-1:0]     cnt_q;
  logic [hbs_pkg::DIV_W-1:0]         num_q;
  logic [hbs_pkg::SPAN_W-1:0]        div_q;
  logic [hbs_pkg::SPAN_W-1:0]        rem_q, rem_d;
  logic [hbs_pkg::DATA_W-1:0]        quo_q;
  logic [hbs_pkg::DIV_STEP-1:0]      qbits;
  logic                              last_step;

  assign done_o     = done_q;
  assign quotient_o = quo_q;
  assign last_step  = busy_q && (cnt_q == hbs_pkg::DIV_CNT_W'(hbs_pkg::DIV_CYC - 1));

  // Restoring division, DIV_STEP dividend bits per cycle. The remainder
  // stays below the divisor, so each step is a narrow compare and subtract.
  always_comb begin
    logic [hbs_pkg::SPAN_W:0] trial;
    rem_d = rem_q;
    qbits = '0;
    for (int i = 0; i < hbs_pkg::DIV_STEP; i++) begin
      trial = {rem_d, num_q[hbs_pkg::DIV_W-1-i]};
      if (trial >= {1'b0, div_q}) begin
        rem_d = hbs_pkg::SPAN_W'(trial - {1'b0, div_q});
        qbits[hbs_pkg::DIV_STEP-1-i] = 1'b1;
      end else begin
        rem_d = trial[hbs_pkg::SPAN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + hbs_pkg::DIV_CNT_W'(1);
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= hbs_pkg::DIV_W'(dividend_i);
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << hbs_pkg::DIV_STEP;
      rem_q <= rem_d;
      quo_q <= {quo_q[hbs_pkg::DATA_W-hbs_pkg::DIV_STEP-1:0], qbits};
    end
  end

endmodule

`default_nettype wire

>>> rtl/hbs_back.sv
`timescale 1ns / 1ps
`default_nettype none

module hbs_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire hbs_pkg::hbs_job_t  job_i,
  input  wire logic               empty_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output hbs_pkg::hbs_out_t       out_data_o
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV  = 2'd1;
  localparam logic [1:0] B_EMIT = 2'd2;

  logic [1:0]                    st_q, st_d;
  logic [hbs_pkg::CNT_W-1:0]     left_q;
  logic                          last_q, short_q;
  logic [hbs_pkg::DATA_W-1:0]    mean_q;
  logic [hbs_pkg::TOTAL_W-1:0]   total_q;
  logic                          out_valid_q;
  hbs_pkg::hbs_out_t             out_q;
  logic                          div_start, div_done;
  logic [hbs_pkg::DATA_W-1:0]    quotient;
  logic                          slot_free, emit_go, fin;
  logic [hbs_pkg::TOTAL_W:0]     total_sum;
  logic [hbs_pkg::TOTAL_W-1:0]   total_sat;

  assign pop_o       = (st_q == B_IDLE) && !empty_i;
  assign div_start   = pop_o && !job_i.too_short;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign emit_go     = (st_q == B_EMIT) && slot_free;
  assign fin         = last_q && (left_q == hbs_pkg::CNT_W'(1));
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign total_sum = {1'b0, total_q} + (hbs_pkg::TOTAL_W + 1)'(mean_q);
  assign total_sat = total_sum[hbs_pkg::TOTAL_W] ? '1
                     : total_sum[hbs_pkg::TOTAL_W-1:0];

  hbs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (job_i.win_sum),
    .divisor_i  (job_i.span),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      B_IDLE: begin
        if (pop_o) begin
          st_d = job_i.too_short ? B_EMIT : B_DIV;
        end
      end
      B_DIV: begin
        if (div_done) begin
          st_d = B_EMIT;
        end
      end
      B_EMIT: begin
        if (emit_go && (left_q == hbs_pkg::CNT_W'(1))) begin
          st_d = B_IDLE;
        end
      end
      default: st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_IDLE;
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      st_q <= st_d;
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (emit_go) begin
        if (short_q || fin) begin
          total_q <= '0;
        end else begin
          total_q <= total_sat;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      left_q  <= job_i.too_short ? hbs_pkg::CNT_W'(1) : job_i.count;
      last_q  <= job_i.is_last;
      short_q <= job_i.too_short;
      mean_q  <= '0;
    end else if (div_done) begin
      mean_q <= quotient;
    end else if (emit_go) begin
      left_q <= left_q - hbs_pkg::CNT_W'(1);
    end
    if (emit_go) begin
      out_q.smoothed_value <= short_q ? '0 : mean_q;
      out_q.result_last    <= short_q || fin;
      out_q.total_points   <= (fin && !short_q) ? total_sat : '0;
      out_q.too_short      <= short_q;
    end
  end

endmodule

`default_nettype wire

>>> rtl/histogram_box_smoother.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   hbs_in_t  (bin_count, last_bin)
// out      output     out_valid_o / out_ready_i hbs_out_t (smoothed_value, result_last,
//                                                          total_points, too_short)
// cfg      input      cfg_we_i (no wait)        cfg_wdata_i (smooth_radius)
//
// The front takes one bin at a time: accepting it shifts the bin into the window, F_SUM1
// and F_SUM2 run the registered adder tree, and F_PUSH queues any job before the next bin.
// The back takes a job when idle, divides unless it is too short (five steps of 8 quotient
// bits over the 37-bit window sum, then done_q hands over), then emits the job's results.
// Reset clears the window, the bin counter, the running total and the radius.
// A stalled output stalls the back; the front keeps going until the two-entry queue is full.

module histogram_box_smoother (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [hbs_pkg::RAD_W-1:0] cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire hbs_pkg::hbs_in_t          in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output hbs_pkg::hbs_out_t              out_data_o
);

  // Radius register. The user must write it only while the block is idle, so every stage may
  // read it directly; the block itself does not enforce this.
  logic [hbs_pkg::RAD_W-1:0] radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  // Jobs carry the window sum, the span, how many results the bin releases
  // and whether it closes the histogram.
  hbs_pkg::hbs_job_t push_job, pop_job;
  logic              push, pop, full, empty;

  hbs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .radius_i   (radius_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .job_o      (push_job)
  );

  hbs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .full_o      (full),
    .empty_o     (empty)
  );

  hbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (pop_job),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // The front must never push into a full queue; a dropped job would lose results.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !full)
    else $error("job pushed into a full queue");

  // The back must never take a job from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !empty)
    else $error("job popped from an empty queue");

  // A queued job either releases results or reports a short histogram, not both.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> ((push_job.count != '0) ^ push_job.too_short))
    else $error("queued job has an inconsistent result count");

  // A short histogram is always closed by its last bin.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && push_job.too_short) |-> push_job.is_last)
    else $error("short histogram job without its last bin");

endmodule

`default_nettype wire

>>> test/histogram_box_smoother_tb.sv
`timescale 1ns / 1ps

// Testbench for the histogram box smoother.
//
// Each accepted bin is pushed through a behavioral copy of the smoother, which
// appends the smoothed bins that the bin releases to a queue of pending results.
// A checker process pops the oldest pending result for every output transaction
// and compares it field by field. The radius is only rewritten once the block has
// drained, and the test sequence runs directed histograms first, then random ones,
// then one longer histogram with no idling at all.
module histogram_box_smoother_tb;
  import hbs_pkg::*;

  localparam int HOLD_OFF_CYCLES = 400;   // long receiver stall that fills the job queue
  localparam int QUIET_CYCLES    = 40;    // front plus divider latency, with margin
  localparam int WATCHDOG_LIMIT  = 3000;  // cycles without any transaction
  localparam int RANDOM_BINS     = 270;
  localparam int LONG_BINS       = 60;    // nearly two widest windows back to back

  localparam logic [TOTAL_W-1:0] TOTAL_CEILING = '1;
  localparam logic [DATA_W-1:0]  COUNT_TOP     = '1;

  // Shapes of the bin counts drawn for one random histogram.
  typedef enum int {
    COUNTS_ANY,
    COUNTS_SMALL,
    COUNTS_TOP,
    COUNTS_MIXED
  } count_shape_e;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [RAD_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_ready;
  hbs_in_t          in_data;
  logic             out_valid;
  logic             out_ready;
  hbs_out_t         out_data;

  histogram_box_smoother dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // Behavioral copy of the smoother: window of the newest bins (newest first),
  // bin counter, running saturating total and the radius last written.
  logic [DATA_W-1:0]  bin_window [WIN_DEPTH];
  int                 bins_taken;
  logic [TOTAL_W-1:0] smoothed_sum;
  logic [RAD_W-1:0]   radius_setting;

  hbs_out_t pending_results[$];

  int  errors;
  int  bins_sent;
  int  histograms_sent;
  int  results_checked;
  int  short_histograms;
  int  saturated_totals;
  int  hold_offs_done;
  int  stuck_cycles;
  bit  idle_en;
  bit  hold_off_req;
  bit  [15:0] radii_written;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void clear_histogram();
    int k;
    for (k = 0; k < WIN_DEPTH; k++) bin_window[k] = '0;
    bins_taken   = 0;
    smoothed_sum = '0;
  endfunction

  // Works out the smoothed bins released by one accepted bin and queues them.
  function automatic void smooth_bin(hbs_in_t item);
    logic [SUM_W-1:0]   wsum;
    logic [SUM_W-1:0]   quot;
    logic [TOTAL_W:0]   acc;
    hbs_out_t           res;
    int                 span;
    int                 prior;
    int                 emit;
    int                 k;
    span  = 2 * int'(radius_setting) + 1;
    prior = bins_taken;
    for (k = WIN_DEPTH - 1; k > 0; k--) bin_window[k] = bin_window[k-1];
    bin_window[0] = item.bin_count;
    wsum = '0;
    for (k = 0; k < span; k++) wsum += SUM_W'(bin_window[k]);
    if (bins_taken < MAX_BINS) bins_taken++;

    // The first full window releases the whole leading edge at once.
    if (prior == span - 1) emit = int'(radius_setting) + 1;
    else if (prior >= span) emit = 1;
    else emit = 0;

    // Histogram ended before the window ever filled.
    if (item.last_bin && emit == 0) begin
      res.smoothed_value = '0;
      res.result_last    = 1'b1;
      res.total_points   = '0;
      res.too_short      = 1'b1;
      pending_results.push_back(res);
      short_histograms++;
      clear_histogram();
      return;
    end

    quot = wsum / SUM_W'(span);
    // The final bin also flushes the trailing edge, which reuses the last window.
    if (item.last_bin) emit += int'(radius_setting);
    for (k = 0; k < emit; k++) begin
      acc = {1'b0, smoothed_sum} + quot[DATA_W-1:0];
      smoothed_sum = (acc > TOTAL_CEILING) ? TOTAL_CEILING : acc[TOTAL_W-1:0];
      res.smoothed_value = quot[DATA_W-1:0];
      res.result_last    = item.last_bin && (k == emit - 1);
      res.total_points   = res.result_last ? smoothed_sum : '0;
      res.too_short      = 1'b0;
      if (res.result_last && smoothed_sum == TOTAL_CEILING) saturated_totals++;
      pending_results.push_back(res);
    end
    if (item.last_bin) clear_histogram();
  endfunction

  function automatic void compare_field(string name, logic [TOTAL_W-1:0] want,
                                        logic [TOTAL_W-1:0] got);
    if (want !== got) begin
      $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Output checker. Both valid and ready are sampled as they were just before
  // the edge, so the comparison does not depend on process order.
  always @(posedge clk) begin : check_results
    hbs_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual value %0h last %0b total %0h short %0b",
                 $time, out_data.smoothed_value, out_data.result_last,
                 out_data.total_points, out_data.too_short);
        errors++;
      end else begin
        want = pending_results.pop_front();
        compare_field("smoothed_value", want.smoothed_value, out_data.smoothed_value);
        compare_field("result_last", want.result_last, out_data.result_last);
        compare_field("total_points", want.total_points, out_data.total_points);
        compare_field("too_short", want.too_short, out_data.too_short);
        results_checked++;
      end
    end
  end

  // Receiver. It normally takes every result, stalls in random bursts while
  // idling is enabled, and on request holds off for one long counted stretch
  // so that the job queue fills and the input side stalls.
  initial begin : receiver
    int n;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        for (n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge clk);
        hold_offs_done++;
        out_ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run if no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // Offers one bin and returns at the edge where it is accepted. Valid stays
  // high across back-to-back calls; a random gap lowers it first.
  task automatic send_bin(input logic [DATA_W-1:0] value, input logic is_last);
    hbs_in_t item;
    item.bin_count = value;
    item.last_bin  = is_last;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    smooth_bin(item);
    bins_sent++;
    if (is_last) histograms_sent++;
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  // Waits until every pending result has arrived, then lets the block finish
  // any bin that releases no result.
  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Radius writes happen only on a drained block.
  task automatic write_radius(input int value);
    stop_sending();
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= RAD_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    radius_setting = RAD_W'(value);
    radii_written[value] = 1'b1;
  endtask

  function automatic logic [DATA_W-1:0] pick_count(count_shape_e shape);
    logic [DATA_W-1:0] value;
    case (shape)
      COUNTS_SMALL: value = $urandom_range(0, 255);
      COUNTS_TOP:   value = COUNT_TOP - $urandom_range(0, 3);
      COUNTS_MIXED: value = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 15);
      default:      value = $urandom;
    endcase
    return value;
  endfunction

  // Radius 0: every bin is its own window. Covers count extremes and a
  // histogram of a single bin.
  task automatic test_single_bin_window();
    write_radius(0);
    send_bin(32'h0000_0000, 1'b0);
    send_bin(COUNT_TOP, 1'b0);
    send_bin(32'h0000_0001, 1'b0);
    send_bin(32'h8000_0000, 1'b0);
    send_bin(32'h7fff_ffff, 1'b1);
    send_bin(COUNT_TOP, 1'b1);
  endtask

  // Histograms that end before the window fills, and one that ends exactly
  // as the first window completes (leading and trailing edges together).
  task automatic test_short_histograms();
    write_radius(3);
    send_bin(32'd5, 1'b0);
    send_bin(32'd6, 1'b0);
    send_bin(32'd7, 1'b0);
    send_bin(32'd8, 1'b1);
    write_radius(1);
    send_bin(32'd9, 1'b1);
    write_radius(2);
    send_bin(32'd10, 1'b0);
    send_bin(32'd20, 1'b0);
    send_bin(32'd30, 1'b0);
    send_bin(32'd40, 1'b0);
    send_bin(32'd51, 1'b1);
  endtask

  // Widest radius with every count at the top, so one bin releases the
  // largest burst of results and the window sum uses all its bits.
  task automatic test_widest_window();
    int i;
    write_radius(15);
    for (i = 0; i < WIN_DEPTH; i++) send_bin(COUNT_TOP, i == WIN_DEPTH - 1);
  endtask

  // Radius rewritten between bins of one histogram. Each bin uses the radius
  // in force when it arrives, both for the window and for the start test.
  task automatic test_radius_change_midway();
    write_radius(2);
    send_bin(32'd100, 1'b0);
    send_bin(32'd200, 1'b0);
    write_radius(1);
    send_bin(32'd300, 1'b0);
    write_radius(4);
    send_bin(32'd400, 1'b0);
    write_radius(0);
    send_bin(32'd500, 1'b0);
    write_radius(2);
    send_bin(32'd600, 1'b1);
  endtask

  // The receiver stops for a long stretch while bins keep coming, so the
  // block backs up all the way to its input.
  task automatic test_output_hold_off();
    int i;
    write_radius(0);
    hold_off_req = 1'b1;
    for (i = 0; i < 40; i++) send_bin($urandom, i == 39);
  endtask

  // Random histograms: mostly well-formed with small radii, now and then a
  // wide radius, a histogram cut short, or a radius change partway through.
  task automatic test_random_histograms();
    int first_bin;
    int r;
    int len;
    int split;
    int i;
    count_shape_e shape;
    first_bin = bins_sent;
    while (bins_sent - first_bin < RANDOM_BINS) begin
      r = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 15) : $urandom_range(0, 4);
      write_radius(r);
      if (r > 0 && $urandom_range(0, 7) == 0) begin
        len = $urandom_range(1, 2 * r);
      end else begin
        len = 2 * r + 1 + $urandom_range(0, 24);
      end
      split = (len > 1 && $urandom_range(0, 5) == 0) ? $urandom_range(1, len - 1) : -1;
      shape = count_shape_e'($urandom_range(0, 3));
      for (i = 0; i < len; i++) begin
        if (i == split) write_radius($urandom_range(0, 4));
        send_bin(pick_count(shape), i == len - 1);
      end
    end
  endtask

  // One longer histogram at the widest radius, every count at the top, sent
  // back to back. A small histogram afterwards shows that the state was cleared.
  task automatic test_long_histogram();
    int i;
    write_radius(15);
    for (i = 0; i < LONG_BINS; i++) send_bin(COUNT_TOP, i == LONG_BINS - 1);
    write_radius(1);
    send_bin(32'd3, 1'b0);
    send_bin(32'd4, 1'b0);
    send_bin(32'd8, 1'b1);
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    idle_en   = 1'b0;
    hold_off_req = 1'b0;
    radii_written = '0;
    radius_setting = '0;
    errors = 0;
    bins_sent = 0;
    histograms_sent = 0;
    results_checked = 0;
    short_histograms = 0;
    saturated_totals = 0;
    hold_offs_done = 0;
    clear_histogram();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_en = 1'b1;
    test_single_bin_window();
    test_short_histograms();
    test_widest_window();
    test_radius_change_midway();
    test_output_hold_off();
    test_random_histograms();

    // Final stretch runs at full rate on both sides.
    idle_en = 1'b0;
    test_long_histogram();

    stop_sending();
    wait_drained();

    $display("covered %0d histograms (%0d too short, %0d saturated totals), %0d bins, %0d results",
             histograms_sent, short_histograms, saturated_totals, bins_sent, results_checked);
    $display("radii written mask %4h, %0d long output stalls, %0d errors",
             radii_written, hold_offs_done, errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
